FILE: rtl/slce_pkg.sv
// Types and constants shared by the sound-log command encoder.
`default_nettype none
package slce_pkg;

	// Input command codes
	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_TICK   = 3'd1;
	localparam logic [2:0] OP_PSG    = 3'd2;
	localparam logic [2:0] OP_STEREO = 3'd3;
	localparam logic [2:0] OP_FM     = 3'd4;
	localparam logic [2:0] OP_STOP   = 3'd5;

	// Stream command bytes
	localparam logic [7:0] CMD_END       = 8'h66;
	localparam logic [7:0] CMD_PSG       = 8'h50;
	localparam logic [7:0] CMD_STEREO    = 8'h4F;
	localparam logic [7:0] CMD_FM        = 8'h51;
	localparam logic [7:0] CMD_WAIT      = 8'h61;
	localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
	localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
	localparam logic [7:0] CMD_WAIT_SHORT = 8'h70;

	localparam logic [15:0] WAIT_NTSC  = 16'd735;
	localparam logic [15:0] WAIT_PAL   = 16'd882;
	localparam logic [15:0] WAIT_SHORT_MAX = 16'd16;

	localparam logic [7:0] FM_PORT_ADDR = 8'hF0;
	localparam logic [7:0] FM_PORT_DATA = 8'hF1;

	// Configuration register addresses
	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-1:0] REG_FM_PRESENT = 3'd0;

	localparam int unsigned MAX_BYTES = 6;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  port;
		logic [7:0]  data_byte;
		logic [15:0] tick_samples;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last_of_run;
		logic        stream_done;
		logic [31:0] total_samples;
	} out_beat_t;

	// Bytes caused by one item; bytes[0] goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      done;
		logic [31:0]               total;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/slce_encode.sv
// Encoder state and per-item byte generation.
`default_nettype none
module slce_encode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slce_pkg::in_beat_t item,
	input  wire logic              take,
	input  wire logic              fm_present,
	output slce_pkg::res_t         res
);

	logic        rec_q, rec_d;
	logic [15:0] pend_q, pend_d;
	logic [31:0] total_q, total_d;
	logic [7:0]  latch_q, latch_d;

	logic [16:0] sum;
	logic [2:0][7:0] f;
	logic [1:0]  fl, fl_use;
	logic [2:0][7:0] t;
	logic [1:0]  tn;
	logic        flush_en;
	logic        done;

	// Wait flush encoding of the pending count
	always_comb begin
		f  = '0;
		fl = 2'd0;
		if (pend_q == 16'd0) begin
			fl = 2'd0;
		end else if (pend_q == slce_pkg::WAIT_NTSC) begin
			f[0] = slce_pkg::CMD_WAIT_NTSC;
			fl   = 2'd1;
		end else if (pend_q == slce_pkg::WAIT_PAL) begin
			f[0] = slce_pkg::CMD_WAIT_PAL;
			fl   = 2'd1;
		end else if (pend_q <= slce_pkg::WAIT_SHORT_MAX) begin
			f[0] = slce_pkg::CMD_WAIT_SHORT + (pend_q[7:0] - 8'd1);
			fl   = 2'd1;
		end else begin
			f[0] = slce_pkg::CMD_WAIT;
			f[1] = pend_q[7:0];
			f[2] = pend_q[15:8];
			fl   = 2'd3;
		end
	end

	always_comb begin
		sum      = {1'b0, pend_q} + {1'b0, item.tick_samples};
		t        = '0;
		tn       = 2'd0;
		flush_en = 1'b0;
		done     = 1'b0;
		rec_d    = rec_q;
		pend_d   = pend_q;
		total_d  = total_q;
		latch_d  = latch_q;
		case (item.command)
			slce_pkg::OP_START: begin
				if (rec_q) begin
					flush_en = 1'b1;
					t[0]     = slce_pkg::CMD_END;
					tn       = 2'd1;
					done     = 1'b1;
				end
				rec_d   = 1'b1;
				pend_d  = '0;
				total_d = '0;
				latch_d = '0;
			end
			slce_pkg::OP_TICK: begin
				if (rec_q) begin
					total_d = total_q + {16'd0, item.tick_samples};
					if (sum[16]) begin
						// carry past the 16-bit limit: emit a full wait, keep the rest
						t[0]   = slce_pkg::CMD_WAIT;
						t[1]   = 8'hFF;
						t[2]   = 8'hFF;
						tn     = 2'd3;
						pend_d = sum[15:0] + 16'd1;
					end else begin
						pend_d = sum[15:0];
					end
				end
			end
			slce_pkg::OP_PSG, slce_pkg::OP_STEREO: begin
				if (rec_q) begin
					flush_en = 1'b1;
					pend_d   = '0;
					t[0]     = (item.command == slce_pkg::OP_PSG) ?
						slce_pkg::CMD_PSG : slce_pkg::CMD_STEREO;
					t[1]     = item.data_byte;
					tn       = 2'd2;
				end
			end
			slce_pkg::OP_FM: begin
				if (rec_q && fm_present) begin
					flush_en = 1'b1;
					pend_d   = '0;
					if (item.port == slce_pkg::FM_PORT_ADDR) begin
						latch_d = item.data_byte;
					end else if (item.port == slce_pkg::FM_PORT_DATA) begin
						t[0] = slce_pkg::CMD_FM;
						t[1] = latch_q;
						t[2] = item.data_byte;
						tn   = 2'd3;
					end
				end
			end
			slce_pkg::OP_STOP: begin
				if (rec_q) begin
					flush_en = 1'b1;
					pend_d   = '0;
					t[0]     = slce_pkg::CMD_END;
					tn       = 2'd1;
					done     = 1'b1;
					rec_d    = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Place the flush bytes ahead of the command bytes
	always_comb begin
		fl_use    = flush_en ? fl : 2'd0;
		res.bytes = '0;
		case (fl_use)
			2'd1: begin
				res.bytes[0] = f[0];
				res.bytes[1] = t[0];
				res.bytes[2] = t[1];
				res.bytes[3] = t[2];
			end
			2'd3: begin
				res.bytes[0] = f[0];
				res.bytes[1] = f[1];
				res.bytes[2] = f[2];
				res.bytes[3] = t[0];
				res.bytes[4] = t[1];
				res.bytes[5] = t[2];
			end
			default: begin
				res.bytes[0] = t[0];
				res.bytes[1] = t[1];
				res.bytes[2] = t[2];
			end
		endcase
		res.cnt   = {1'b0, fl_use} + {1'b0, tn};
		res.done  = done;
		res.total = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q   <= 1'b0;
			pend_q  <= '0;
			total_q <= '0;
			latch_q <= '0;
		end else if (take) begin
			rec_q   <= rec_d;
			pend_q  <= pend_d;
			total_q <= total_d;
			latch_q <= latch_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/slce_serializer.sv
// Result buffer that sends the bytes of one item one beat at a time.
`default_nettype none
module slce_serializer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire slce_pkg::res_t     res,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output slce_pkg::out_beat_t     out_beat
);

	logic [slce_pkg::MAX_BYTES-1:0][7:0] buf_q;
	logic [2:0]  cnt_q;
	logic        done_q;
	logic [31:0] total_q;
	logic        last;

	assign out_valid = (cnt_q != 3'd0);
	assign last      = (cnt_q == 3'd1);
	assign free      = !out_valid || (last && out_ready);

	always_comb begin
		out_beat.out_byte      = buf_q[0];
		out_beat.last_of_run   = last;
		out_beat.stream_done   = last && done_q;
		out_beat.total_samples = (last && done_q) ? total_q : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q   <= res.bytes;
			done_q  <= res.done;
			total_q <= res.total;
		end else if (out_valid && out_ready) begin
			buf_q <= {8'h00, buf_q[slce_pkg::MAX_BYTES-1:1]};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sound_log_command_encoder.sv
// Top level of the sound-log command encoder.
//
// Usage:
//  - cmd channel (cmd_valid/cmd_ready/cmd): one beat per sound-chip event or
//    time tick. Ticks add to a pending wait; register writes and stop flush
//    that wait as a wait command ahead of their own bytes.
//  - stream channel (stream_valid/stream_ready/stream): one command byte per
//    beat. last_of_run marks the final byte caused by a cmd beat; stream_done
//    and total_samples mark the end-of-data byte.
//  - APB port: register 0 (fm_chip_present) at address 0; pready is always 1.
// Path: a cmd beat lands in the input register, is encoded into the byte
// buffer once that buffer is free, and its first byte is then valid on
// stream. Beats that cause no byte leave nothing on stream.
// Throughput: one cmd beat per cycle while each causes at most one byte and
// stream is not stalled; a beat causing more bytes (up to six) holds the
// byte buffer until its last byte is sent, one byte per stream beat.
// Reset: clears recording state, pending wait, sample total, register latch,
// fm_chip_present and both buffers. When stream stalls, hold the byte buffer;
// the input register still takes one more cmd beat before cmd_ready drops.
`default_nettype none
module sound_log_command_encoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// command beats
	input  wire logic                              cmd_valid,
	output logic                                   cmd_ready,
	input  wire slce_pkg::in_beat_t                cmd,
	// byte stream beats
	output logic                                   stream_valid,
	input  wire logic                              stream_ready,
	output slce_pkg::out_beat_t                    stream,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [slce_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	slce_pkg::in_beat_t s1_beat_s1;
	logic               s1_valid_q;
	logic               fm_present_q;
	logic               buf_free;
	logic               s1_move;
	slce_pkg::res_t     res;

	// APB register: written on the access phase
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_present_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& paddr == slce_pkg::REG_FM_PRESENT) begin
			fm_present_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == slce_pkg::REG_FM_PRESENT) ? {31'd0, fm_present_q} : 32'd0;

	// Input register: advance into the encoder whenever the byte buffer frees up
	assign s1_move   = s1_valid_q && buf_free;
	assign cmd_ready = !s1_valid_q || s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd_ready) begin
			s1_valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			s1_beat_s1 <= cmd;
		end
	end

	// Encode against the current state; state advances as the beat moves on
	slce_encode u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (s1_beat_s1),
		.take       (s1_move),
		.fm_present (fm_present_q),
		.res        (res)
	);

	// Byte buffer: drop zero-byte results, send the rest one beat at a time
	slce_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_move),
		.res       (res),
		.free      (buf_free),
		.out_valid (stream_valid),
		.out_ready (stream_ready),
		.out_beat  (stream)
	);

	// End-of-data beat is always the 0x66 byte and closes its run
	a_done_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && stream.stream_done |->
			stream.out_byte == slce_pkg::CMD_END && stream.last_of_run)
		else $error("stream_done on a byte other than the end command");

	// Total is only carried on the end-of-data beat
	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream.stream_done |-> stream.total_samples == 32'd0)
		else $error("total_samples nonzero outside end-of-data beat");

	// Backpressure on cmd only while the input register holds a stalled beat
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> s1_valid_q && stream_valid)
		else $error("cmd_ready low without a stalled beat");

	// A stalled byte buffer keeps the input register from moving
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream_ready |-> !s1_move)
		else $error("encoder advanced while stream stalled");

endmodule
`default_nettype wire
